>>> src/ddpid_pkg.sv
// shared types, constants and register codes for the dual pid drive controller
package ddpid_pkg;

    localparam int CFG_BITS       = 24;
    localparam int CFG_COUNT      = 8;
    localparam int CFG_IDX_BITS   = $clog2(CFG_COUNT);
    localparam int OUT_BITS       = 32;
    localparam int OUT_FRAC_BITS  = 16;

    localparam int DEF_POSITION_BITS      = 24;
    localparam int DEF_SUM_BITS           = 40;
    localparam int DEF_GAIN_FRACTION_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LAT_P_GAIN   = 3'd0,
        CFG_LAT_I_GAIN   = 3'd1,
        CFG_LAT_D_GAIN   = 3'd2,
        CFG_TURN_P_GAIN  = 3'd3,
        CFG_TURN_I_GAIN  = 3'd4,
        CFG_TURN_D_GAIN  = 3'd5,
        CFG_DIST_TARGET  = 3'd6,
        CFG_TURN_TARGET  = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic load_err;
        logic update;
        logic load_prod;
        logic load_pow;
    } t_pipe_ctl;

endpackage

>>> src/ddpid_loop.sv
// one pid loop: error state, saturating sum, split products and power sum
module ddpid_loop import ddpid_pkg::*; #(
    parameter int ERR_BITS = 26,
    parameter int SUM_BITS = DEF_SUM_BITS,
    parameter int POW_BITS = 68
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_pipe_ctl                  i_ctl,
    input  logic signed [ERR_BITS-1:0] i_err,
    input  logic signed [CFG_BITS-1:0] i_kp,
    input  logic signed [CFG_BITS-1:0] i_ki,
    input  logic signed [CFG_BITS-1:0] i_kd,
    output logic signed [POW_BITS-1:0] o_power
);

    localparam int DIF_BITS = ERR_BITS + 1;
    localparam int SW       = ((SUM_BITS > ERR_BITS) ? SUM_BITS : ERR_BITS) + 1;
    localparam int HI_BITS  = SUM_BITS - CFG_BITS;
    localparam int LO_PROD  = 2 * CFG_BITS + 1;

    localparam logic signed [SW-1:0] SUM_HI = {{(SW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_LO = {{(SW-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};

    logic signed [ERR_BITS-1:0]          r_last;
    logic signed [SUM_BITS-1:0]          r_sum;
    logic signed [SW-1:0]                n_sum_wide;
    logic signed [SUM_BITS-1:0]          n_sum;
    logic signed [DIF_BITS-1:0]          n_dif;

    logic signed [ERR_BITS-1:0]          r_e;
    logic signed [DIF_BITS-1:0]          r_d;
    logic signed [SUM_BITS-1:0]          r_s;

    logic signed [ERR_BITS+CFG_BITS-1:0] r_pe;
    logic signed [DIF_BITS+CFG_BITS-1:0] r_pd;
    logic signed [LO_PROD-1:0]           r_plo;
    logic signed [HI_BITS+CFG_BITS-1:0]  r_phi;
    logic signed [POW_BITS-1:0]          r_pow;

    always_comb begin
        n_sum_wide = SW'(r_sum) + SW'(i_err);
        if (n_sum_wide > SUM_HI) begin
            n_sum = SUM_HI[SUM_BITS-1:0];
        end else if (n_sum_wide < SUM_LO) begin
            n_sum = SUM_LO[SUM_BITS-1:0];
        end else begin
            n_sum = n_sum_wide[SUM_BITS-1:0];
        end
        n_dif = DIF_BITS'(i_err) - DIF_BITS'(r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_sum  <= '0;
        end else if (i_ctl.update) begin
            r_last <= i_err;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_err) begin
            r_e <= i_err;
            r_d <= n_dif;
            r_s <= n_sum;
        end
        if (i_ctl.load_prod) begin
            r_pe  <= r_e * i_kp;
            r_pd  <= r_d * i_kd;
            r_plo <= $signed({1'b0, r_s[CFG_BITS-1:0]}) * i_ki;
            r_phi <= $signed(r_s[SUM_BITS-1:CFG_BITS]) * i_ki;
        end
        if (i_ctl.load_pow) begin
            r_pow <= POW_BITS'(r_pe) + POW_BITS'(r_pd) + POW_BITS'(r_plo)
                   + (POW_BITS'(r_phi) <<< CFG_BITS);
        end
    end

    assign o_power = r_pow;

endmodule

>>> src/differential_drive_dual_pid.sv
// top level of the dual pid differential drive controller
//
// channel | signals                                   | direction
// input   | i_in_valid / o_in_ready, positions        | request in
// output  | o_out_valid / i_out_ready, drives         | request out
// config  | i_cfg_valid / o_cfg_ready, index, data    | register write in
//
// six register stages, one request per cycle while the output is not stalled
// an accepted request passes the position, error, loop, product, power and drive registers before output valid
// error state and sums update as a request enters the third stage
// each stage advances when empty or when the next stage advances
// synchronous active-low reset clears configuration registers, loop state and valid bits
module differential_drive_dual_pid import ddpid_pkg::*; #(
    parameter int POSITION_BITS      = DEF_POSITION_BITS,
    parameter int SUM_BITS           = DEF_SUM_BITS,
    parameter int GAIN_FRACTION_BITS = DEF_GAIN_FRACTION_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [POSITION_BITS-1:0] i_left_position,
    input  logic signed [POSITION_BITS-1:0] i_right_position,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [OUT_BITS-1:0]      o_left_drive,
    output logic signed [OUT_BITS-1:0]      o_right_drive,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [CFG_BITS-1:0]             i_cfg_data
);

    localparam int P    = POSITION_BITS;
    localparam int LE   = ((P > CFG_BITS) ? P : CFG_BITS) + 1;
    localparam int TE   = ((P + 1 > CFG_BITS) ? P + 1 : CFG_BITS) + 1;
    localparam int W    = ((TE + 1 > SUM_BITS) ? TE + 1 : SUM_BITS) + CFG_BITS + 2;
    localparam int SHL  = (GAIN_FRACTION_BITS < OUT_FRAC_BITS) ?
                          OUT_FRAC_BITS - GAIN_FRACTION_BITS : 0;
    localparam int SHR  = (GAIN_FRACTION_BITS > OUT_FRAC_BITS) ?
                          GAIN_FRACTION_BITS - OUT_FRAC_BITS : 0;
    localparam int XW   = W + 1 + SHL;

    localparam logic signed [XW-1:0] SAT_HI = {{(XW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = {{(XW-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

    logic signed [CFG_BITS-1:0] r_cfg [CFG_COUNT];

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic adv1, adv2, adv3, adv4, adv5, adv6;

    logic signed [P-1:0]  r_l;
    logic signed [P-1:0]  r_r;
    logic signed [P:0]    n_lr_sum;
    logic signed [P:0]    n_lr_adj;
    logic signed [LE-1:0] n_lat_e;
    logic signed [TE-1:0] n_turn_e;
    logic signed [LE-1:0] r_lat_e;
    logic signed [TE-1:0] r_turn_e;

    t_pipe_ctl            ctl;
    logic signed [W-1:0]  lat_pow;
    logic signed [W-1:0]  turn_pow;
    logic signed [XW-1:0] n_lw;
    logic signed [XW-1:0] n_rw;
    logic signed [OUT_BITS-1:0] n_left;
    logic signed [OUT_BITS-1:0] n_right;
    logic signed [OUT_BITS-1:0] r_left_drive;
    logic signed [OUT_BITS-1:0] r_right_drive;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_COUNT; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LAT_P_GAIN:  r_cfg[CFG_LAT_P_GAIN]  <= i_cfg_data;
                CFG_LAT_I_GAIN:  r_cfg[CFG_LAT_I_GAIN]  <= i_cfg_data;
                CFG_LAT_D_GAIN:  r_cfg[CFG_LAT_D_GAIN]  <= i_cfg_data;
                CFG_TURN_P_GAIN: r_cfg[CFG_TURN_P_GAIN] <= i_cfg_data;
                CFG_TURN_I_GAIN: r_cfg[CFG_TURN_I_GAIN] <= i_cfg_data;
                CFG_TURN_D_GAIN: r_cfg[CFG_TURN_D_GAIN] <= i_cfg_data;
                CFG_DIST_TARGET: r_cfg[CFG_DIST_TARGET] <= i_cfg_data;
                CFG_TURN_TARGET: r_cfg[CFG_TURN_TARGET] <= i_cfg_data;
            endcase
        end
    end

    // pipeline flow control
    assign adv6 = !r_v6 || i_out_ready;
    assign adv5 = !r_v5 || adv6;
    assign adv4 = !r_v4 || adv5;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_in_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
            if (adv5) r_v5 <= r_v4;
            if (adv6) r_v6 <= r_v5;
        end
    end

    // error forming
    always_comb begin
        n_lr_sum = (P+1)'(r_l) + (P+1)'(r_r);
        n_lr_adj = n_lr_sum + $signed({{P{1'b0}}, n_lr_sum[P]});
        n_lat_e  = LE'($signed(n_lr_adj[P:1])) - LE'(r_cfg[CFG_DIST_TARGET]);
        n_turn_e = TE'(r_l) - TE'(r_r) - TE'(r_cfg[CFG_TURN_TARGET]);
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_l <= i_left_position;
            r_r <= i_right_position;
        end
        if (adv2) begin
            r_lat_e  <= n_lat_e;
            r_turn_e <= n_turn_e;
        end
    end

    always_comb begin
        ctl.load_err  = adv3;
        ctl.update    = adv3 && r_v2;
        ctl.load_prod = adv4;
        ctl.load_pow  = adv5;
    end

    ddpid_loop #(
        .ERR_BITS (LE),
        .SUM_BITS (SUM_BITS),
        .POW_BITS (W)
    ) u_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_err   (r_lat_e),
        .i_kp    (r_cfg[CFG_LAT_P_GAIN]),
        .i_ki    (r_cfg[CFG_LAT_I_GAIN]),
        .i_kd    (r_cfg[CFG_LAT_D_GAIN]),
        .o_power (lat_pow)
    );

    ddpid_loop #(
        .ERR_BITS (TE),
        .SUM_BITS (SUM_BITS),
        .POW_BITS (W)
    ) u_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_err   (r_turn_e),
        .i_kp    (r_cfg[CFG_TURN_P_GAIN]),
        .i_ki    (r_cfg[CFG_TURN_I_GAIN]),
        .i_kd    (r_cfg[CFG_TURN_D_GAIN]),
        .o_power (turn_pow)
    );

    // mix, rescale and saturate
    always_comb begin
        n_lw = ((XW'(lat_pow) + XW'(turn_pow)) <<< SHL) >>> SHR;
        n_rw = ((XW'(lat_pow) - XW'(turn_pow)) <<< SHL) >>> SHR;
        if (n_lw > SAT_HI) begin
            n_left = SAT_HI[OUT_BITS-1:0];
        end else if (n_lw < SAT_LO) begin
            n_left = SAT_LO[OUT_BITS-1:0];
        end else begin
            n_left = n_lw[OUT_BITS-1:0];
        end
        if (n_rw > SAT_HI) begin
            n_right = SAT_HI[OUT_BITS-1:0];
        end else if (n_rw < SAT_LO) begin
            n_right = SAT_LO[OUT_BITS-1:0];
        end else begin
            n_right = n_rw[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv6) begin
            r_left_drive  <= n_left;
            r_right_drive <= n_right;
        end
    end

    assign o_out_valid   = r_v6;
    assign o_left_drive  = r_left_drive;
    assign o_right_drive = r_right_drive;

endmodule

>>> src/ddpid_chk.sv
// port-level checks for the dual pid drive controller, bound to the top level
module ddpid_chk import ddpid_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [OUT_BITS-1:0] o_left_drive,
    input logic signed [OUT_BITS-1:0] o_right_drive
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output request dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_left_drive) && $stable(o_right_drive))
        else $error("output payload changed while stalled");

endmodule

bind differential_drive_dual_pid ddpid_chk u_ddpid_chk (.*);
